// ----- design/ttsr_pkg.sv -----
`default_nettype none

package ttsr_pkg;

  // table geometry: 8 variables, 256 minterms
  localparam int TBL_VARS = 8;
  localparam int TBL_W    = 256;

  typedef struct packed {
    logic [63:0] table_word0;
    logic [63:0] table_word1;
    logic [63:0] table_word2;
    logic [63:0] table_word3;
    logic [3:0]  var_count;
  } item_t;

  typedef struct packed {
    logic [63:0] reduced_word0;
    logic [63:0] reduced_word1;
    logic [63:0] reduced_word2;
    logic [63:0] reduced_word3;
    logic [3:0]  support_count;
    logic [7:0]  kept_mask;
  } result_t;

  // source minterm for output minterm y when variable j is rotated up to
  // position k-1 and variables j+1..k-1 each move down by one
  function automatic logic [7:0] rot_src(input logic [7:0] y, input int j, input int k);
    logic [7:0] x;
    int d;
    for (int v = 0; v < TBL_VARS; v++) begin
      if (v == j) begin
        d = k - 1;
      end else if (v > j && v < k) begin
        d = v - 1;
      end else begin
        d = v;
      end
      x[3'(v)] = y[3'(d)];
    end
    return x;
  endfunction

endpackage

`default_nettype wire

// ----- design/truth_table_support_reduce_top.sv -----
`default_nettype none

// Truth table support reduction.
// An item on the item channel carries a 256-minterm table over up to eight
// variables and the number of variables in use (saturated to MAX_VARS).
// The result channel returns the table with every variable it does not
// depend on rotated above the used range, the remaining variables in their
// original order, the number kept and a mask of the kept original positions.
// Each variable is handled by its own register stage, highest first, behind
// one input register; an item passes the input register and then every stage
// in turn before result_valid. A new item can be taken in every cycle, so
// throughput is one item per cycle while the receiver keeps result_ready high.
// When the receiver stalls, the result waits in the last stage and the
// stages behind it fill up; item_ready falls only once every stage holds an
// item, and nothing is dropped or repeated.
// Reset empties the pipeline; no table state is kept between items.
module truth_table_support_reduce_top #(
  parameter int MAX_VARS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire ttsr_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output ttsr_pkg::result_t      result
);

  import ttsr_pkg::*;

  localparam int L     = MAX_VARS;
  localparam int CNT_W = $clog2(MAX_VARS + 1);

  // stage registers: stage 0 is the input register, stage s handles
  // variable MAX_VARS - s
  logic                 vld_q  [0:L];
  logic [TBL_W-1:0]     tbl_q  [0:L];
  logic [CNT_W-1:0]     cnt_q  [0:L];
  logic [TBL_VARS-1:0]  mask_q [0:L];

  logic [TBL_W-1:0]     tbl_next  [1:L];
  logic [CNT_W-1:0]     cnt_next  [1:L];
  logic [TBL_VARS-1:0]  mask_next [1:L];

  logic [L+1:0]         adv;
  logic [CNT_W-1:0]     in_cnt;

  // stage moves when it is empty or the stage after it moves
  always_comb begin
    adv[L+1] = result_ready;
    for (int s = L; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign item_ready = adv[0];

  // saturate the variable count
  always_comb begin
    if (item.var_count > 4'(MAX_VARS)) begin
      in_cnt = CNT_W'(MAX_VARS);
    end else begin
      in_cnt = item.var_count[CNT_W-1:0];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (adv[0]) begin
      vld_q[0] <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && item_valid) begin
      tbl_q[0]  <= {item.table_word3, item.table_word2, item.table_word1, item.table_word0};
      cnt_q[0]  <= in_cnt;
      mask_q[0] <= '0;
    end
  end

  // one stage per variable, highest first
  for (genvar s = 1; s <= L; s++) begin : g_stage
    localparam int J = MAX_VARS - s;

    logic             dep;
    logic             active;
    logic [TBL_W-1:0] rot;

    // does the table depend on variable J
    always_comb begin
      dep = 1'b0;
      for (int y = 0; y < TBL_W; y++) begin
        if ((y & (1 << J)) == 0) begin
          dep = dep | (tbl_q[s-1][8'(y)] ^ tbl_q[s-1][8'(y | (1 << J))]);
        end
      end
    end

    assign active = cnt_q[s-1] > CNT_W'(J);

    // rotate variable J up to the top of the used range
    always_comb begin
      rot = tbl_q[s-1];
      for (int k = J + 1; k <= MAX_VARS; k++) begin
        if (cnt_q[s-1] == CNT_W'(k)) begin
          for (int y = 0; y < TBL_W; y++) begin
            rot[8'(y)] = tbl_q[s-1][rot_src(8'(y), J, k)];
          end
        end
      end
    end

    // drop or keep variable J
    always_comb begin
      tbl_next[s]  = tbl_q[s-1];
      cnt_next[s]  = cnt_q[s-1];
      mask_next[s] = mask_q[s-1];
      if (active && !dep) begin
        tbl_next[s] = rot;
        cnt_next[s] = cnt_q[s-1] - CNT_W'(1);
      end else if (active) begin
        mask_next[s] = mask_q[s-1] | (TBL_VARS'(1) << J);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (adv[s]) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s] && vld_q[s-1]) begin
        tbl_q[s]  <= tbl_next[s];
        cnt_q[s]  <= cnt_next[s];
        mask_q[s] <= mask_next[s];
      end
    end
  end

  // result from the last stage
  assign result_valid         = vld_q[L];
  assign result.reduced_word0 = tbl_q[L][63:0];
  assign result.reduced_word1 = tbl_q[L][127:64];
  assign result.reduced_word2 = tbl_q[L][191:128];
  assign result.reduced_word3 = tbl_q[L][255:192];
  assign result.support_count = 4'(cnt_q[L]);
  assign result.kept_mask     = mask_q[L];

  // kept count and mask agree
  a_mask_count: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($countones(result.kept_mask) == int'(result.support_count)))
    else $error("kept mask does not match support count");

  // count never exceeds the variable limit
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.support_count <= 4'(MAX_VARS)))
    else $error("support count out of range");

  // no kept position at or above the variable limit
  a_mask_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.kept_mask >> MAX_VARS) == '0))
    else $error("kept mask has a position beyond the limit");

  // an empty last stage always lets a transfer in
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
